// File: hw/rtl/fbfl_pkg.sv
package fbfl_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 256;

  localparam int unsigned BS_W   = 16;  // bytes per block register
  localparam int unsigned BC_W   = 9;   // block_count register
  localparam int unsigned CFG_W  = 16;  // configuration write data
  localparam int unsigned OFF_W  = 24;  // byte offsets
  localparam int unsigned IDX_W  = 8;   // block_index output
  localparam int unsigned BSD_W  = 14;  // block size in units of eight bytes
  localparam int unsigned QW     = OFF_W - 3;      // offset in units of eight bytes
  localparam int unsigned LIM_W  = BSD_W + BC_W;   // pool size in units of eight bytes

  localparam logic CFG_BLK_BYTES   = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_RANGE    = 2'd2,
    ST_MISALIGN = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_POP,
    S_MUL,
    S_LIMIT,
    S_DIV
  } state_e;

  typedef struct packed {
    logic    load_req;
    logic    take_top;
    logic    take_fresh;
    logic    pop;
    logic    div_start;
    logic    push;
    logic    out_alloc;
    logic    out_free;
    logic    out_err;
    status_e err_code;
  } cmd_t;

  typedef struct packed {
    logic top_avail;
    logic fresh_avail;
    logic div_done;
    logic range_err;
    logic misalign;
  } sts_t;

endpackage

// File: hw/rtl/fixed_block_free_list_allocator.sv
// Allocate runs ALLOC alone when the pool is empty, ALLOC then MUL for a never-used
// block, ALLOC, POP, MUL for a block popped from the free stack (one link RAM read).
// Free: LIMIT, then DIV while the bit-serial divider yields one of 21 quotient bits
// per cycle. One request at a time; a new request is taken while the result strobes.
// Reset empties the free stack, marks no block as handed out, and sets the bytes per
// block to 8 and block_count to 256. The link RAM needs no clearing pass.
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               start,
  output logic               busy,
  input  logic               operation_i,
  input  logic [OFF_W-1:0]   free_offset_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [IDX_W-1:0]   block_index_o,
  output logic [OFF_W-1:0]   block_offset_o
);

  cmd_t cmd;
  sts_t sts;

  fbfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  fbfl_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .free_offset_i  (free_offset_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .done_o         (done_o),
    .status_o       (status_o),
    .block_index_o  (block_index_o),
    .block_offset_o (block_offset_o)
  );

endmodule

// File: hw/rtl/fbfl_ram.sv
module fbfl_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/fbfl_div.sv
module fbfl_div #(
  parameter int unsigned NW = 21,
  parameter int unsigned DW = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo_q, quo_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    dvs_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DW:0]      trial;
  logic [DW:0]      diff;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    diff  = trial - {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CNT_W'(NW);
    end else if (cnt_q != '0) begin
      if (!diff[DW]) begin
        rem_d = diff[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: hw/rtl/fbfl_ctrl.sv
module fbfl_ctrl
  import fbfl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  logic operation_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = (op_e'(operation_i) == OP_FREE) ? S_LIMIT : S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (sts_i.top_avail) begin
          state_d = S_POP;
        end else if (sts_i.fresh_avail) begin
          state_d = S_MUL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_POP:   state_d = S_MUL;
      S_MUL:   state_d = S_IDLE;
      S_LIMIT: state_d = S_DIV;
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.err_code = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_req = start;
      end
      S_ALLOC: begin
        if (sts_i.top_avail) begin
          cmd_o.take_top = 1'b1;
        end else if (sts_i.fresh_avail) begin
          cmd_o.take_fresh = 1'b1;
        end else begin
          cmd_o.out_err  = 1'b1;
          cmd_o.err_code = ST_EMPTY;
        end
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
      end
      S_MUL: begin
        cmd_o.out_alloc = 1'b1;
      end
      S_LIMIT: begin
        cmd_o.div_start = 1'b1;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          // The range check takes precedence over the alignment check.
          if (sts_i.range_err) begin
            cmd_o.out_err  = 1'b1;
            cmd_o.err_code = ST_RANGE;
          end else if (sts_i.misalign) begin
            cmd_o.out_err  = 1'b1;
            cmd_o.err_code = ST_MISALIGN;
          end else begin
            cmd_o.push     = 1'b1;
            cmd_o.out_free = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// File: hw/rtl/fbfl_dp.sv
module fbfl_dp
  import fbfl_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic [OFF_W-1:0]   free_offset_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [IDX_W-1:0]   block_index_o,
  output logic [OFF_W-1:0]   block_offset_o
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned PW = IW + 1;
  localparam int unsigned CW = (PW > BC_W) ? PW : BC_W;
  localparam int unsigned MW = IW + BSD_W;

  logic [BS_W-1:0]  bs_cfg_q;
  logic [BC_W-1:0]  bc_cfg_q;
  logic [OFF_W-1:0] off_q;
  logic [IW-1:0]    idx_q;
  logic [PW-1:0]    top_q, top_d;
  logic [PW-1:0]    fresh_q, fresh_d;
  logic [LIM_W-1:0] lim_q;
  logic             done_q;
  status_e          status_q;
  logic [IDX_W-1:0] bidx_q;
  logic [OFF_W-1:0] boff_q;

  logic [BS_W:0]    bs_round;
  logic [BSD_W-1:0] bsd;
  logic [CW-1:0]    bc_ext;
  logic [CW-1:0]    cnt_used;
  logic [BC_W-1:0]  cnt9;
  logic [MW-1:0]    prod;
  logic [QW-1:0]    quot;
  logic [BSD_W-1:0] rem;
  logic             div_done;
  logic [PW-1:0]    ram_rdata;
  logic [IW-1:0]    push_idx;

  // Block size in units of eight bytes: rounded up, and never below one.
  always_comb begin
    bs_round = {1'b0, bs_cfg_q} + (BS_W + 1)'(7);
    bsd      = (bs_cfg_q < BS_W'(8)) ? BSD_W'(1) : bs_round[BS_W:3];
    bc_ext   = CW'(bc_cfg_q);
    cnt_used = (bc_ext > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : bc_ext;
    cnt9     = cnt_used[BC_W-1:0];
    prod     = MW'(idx_q) * MW'(bsd);
    push_idx = quot[IW-1:0];
  end

  assign sts_o.top_avail   = (top_q < PW'(MAX_BLOCKS));
  assign sts_o.fresh_avail = (CW'(fresh_q) < cnt_used);
  assign sts_o.div_done    = div_done;
  assign sts_o.range_err   = (LIM_W'(off_q[OFF_W-1:3]) >= lim_q);
  assign sts_o.misalign    = (off_q[2:0] != 3'b000) || (rem != '0);

  fbfl_div #(
    .NW (QW),
    .DW (BSD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (off_q[OFF_W-1:3]),
    .divisor_i  (bsd),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // Each entry holds the block below it on the free stack.
  fbfl_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (push_idx),
    .wdata_i (top_q),
    .raddr_i (top_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    top_d   = top_q;
    fresh_d = fresh_q;
    if (cmd_i.pop) begin
      top_d = ram_rdata;
    end else if (cmd_i.push) begin
      top_d = PW'(push_idx);
    end
    if (cmd_i.take_fresh) begin
      fresh_d = fresh_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_cfg_q <= BS_W'(8);
      bc_cfg_q <= BC_W'(256);
      top_q    <= PW'(MAX_BLOCKS);
      fresh_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BLK_BYTES:   bs_cfg_q <= cfg_wdata_i[BS_W-1:0];
          CFG_BLOCK_COUNT: bc_cfg_q <= cfg_wdata_i[BC_W-1:0];
          default: ;
        endcase
      end
      top_q   <= top_d;
      fresh_q <= fresh_d;
      done_q  <= cmd_i.out_alloc | cmd_i.out_free | cmd_i.out_err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      off_q <= free_offset_i;
    end
    if (cmd_i.take_top) begin
      idx_q <= top_q[IW-1:0];
    end else if (cmd_i.take_fresh) begin
      idx_q <= fresh_q[IW-1:0];
    end
    if (cmd_i.div_start) begin
      lim_q <= LIM_W'(bsd) * LIM_W'(cnt9);
    end
    if (cmd_i.out_alloc) begin
      status_q <= ST_OK;
      bidx_q   <= IDX_W'(idx_q);
      boff_q   <= OFF_W'({prod, 3'b000});
    end else if (cmd_i.out_free) begin
      status_q <= ST_OK;
      bidx_q   <= IDX_W'(push_idx);
      boff_q   <= off_q;
    end else if (cmd_i.out_err) begin
      status_q <= cmd_i.err_code;
      bidx_q   <= '0;
      boff_q   <= '0;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign block_index_o  = bidx_q;
  assign block_offset_o = boff_q;

endmodule

// File: hw/rtl/fbfl_chk.sv
module fbfl_chk
  import fbfl_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input logic [1:0]       status_o,
  input logic [IDX_W-1:0] block_index_o,
  input logic [OFF_W-1:0] block_offset_o
);

  // An error result carries no block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> (block_index_o == '0) && (block_offset_o == '0))
    else $error("error result with nonzero block fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted request did not make the block busy");

  // The result strobes in the cycle the controller is back in idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in consecutive cycles");

endmodule

bind fixed_block_free_list_allocator fbfl_chk u_fbfl_chk (.*);

// File: sim/tb_fixed_block_free_list_allocator.sv
`timescale 1ns / 100ps

module tb_fixed_block_free_list_allocator;
  import fbfl_pkg::*;

  localparam int unsigned POOL_MAX = MAX_BLOCKS_DEF;
  localparam int unsigned SETTLE   = 30;  // longer than the slowest request
  localparam int unsigned CHUNK    = 40;

  typedef struct packed {
    op_e              op;
    logic [OFF_W-1:0] off;
  } pool_req_t;

  typedef struct packed {
    status_e          st;
    logic [IDX_W-1:0] idx;
    logic [OFF_W-1:0] boff;
  } pool_rsp_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = CFG_BLK_BYTES;
  logic [CFG_W-1:0]   cfg_wdata_i = '0;
  logic               start = 1'b0;
  logic               busy;
  logic               operation_i = OP_ALLOC;
  logic [OFF_W-1:0]   free_offset_i = '0;
  logic               done_o;
  logic [1:0]         status_o;
  logic [IDX_W-1:0]   block_index_o;
  logic [OFF_W-1:0]   block_offset_o;

  // Shadow of the allocator state and its configuration.
  logic [BS_W-1:0]    cfg_size = 16'd8;
  logic [BC_W-1:0]    cfg_count = 9'd256;
  int unsigned        blk_link [POOL_MAX];
  int unsigned        stack_top = POOL_MAX;
  int unsigned        fresh_cnt = 0;
  int unsigned        held_q [$];   // blocks currently handed out

  pool_req_t          pend_q [$];
  pool_rsp_t          pool_results_q [$];
  pool_req_t          next_req;
  pool_req_t          sent_req;
  pool_rsp_t          want;
  int unsigned        idle_pct = 0;
  int unsigned        mismatches = 0;

  fixed_block_free_list_allocator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .free_offset_i  (free_offset_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .block_index_o  (block_index_o),
    .block_offset_o (block_offset_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned used_size();
    int unsigned us;
    us = (32'(cfg_size) + 32'd7) & ~32'd7;
    return (us < 8) ? 8 : us;
  endfunction

  function automatic int unsigned used_count();
    return (32'(cfg_count) > POOL_MAX) ? POOL_MAX : 32'(cfg_count);
  endfunction

  function automatic pool_rsp_t pool_step(pool_req_t r);
    int unsigned us;
    int unsigned cnt;
    int unsigned blk;
    pool_rsp_t   rsp;
    us = used_size();
    cnt = used_count();
    rsp.st = ST_OK;
    rsp.idx = '0;
    rsp.boff = '0;
    if (r.op == OP_ALLOC) begin
      // Returned blocks go out first, then blocks that were never used.
      if (stack_top < POOL_MAX) begin
        blk = stack_top;
        stack_top = blk_link[blk];
      end else if (fresh_cnt < cnt) begin
        blk = fresh_cnt;
        fresh_cnt++;
      end else begin
        rsp.st = ST_EMPTY;
        return rsp;
      end
      rsp.idx = IDX_W'(blk);
      rsp.boff = OFF_W'(blk * us);
      held_q.push_back(blk);
    end else if (32'(r.off) >= us * cnt) begin
      rsp.st = ST_RANGE;
    end else if (32'(r.off) % us != 0) begin
      rsp.st = ST_MISALIGN;
    end else begin
      blk = 32'(r.off) / us;
      blk_link[blk] = stack_top;
      stack_top = blk;
      rsp.idx = IDX_W'(blk);
      rsp.boff = r.off;
      for (int i = 0; i < held_q.size(); i++) begin
        if (held_q[i] == blk) begin
          held_q.delete(i);
          break;
        end
      end
    end
    return rsp;
  endfunction

  // Request driver: may offer the next pending request whenever the slot is free.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        sent_req.op = op_e'(operation_i);
        sent_req.off = free_offset_i;
        pool_results_q.push_back(pool_step(sent_req));
      end
      if (!start || !busy) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_req = pend_q.pop_front();
          start <= 1'b1;
          operation_i <= next_req.op;
          free_offset_i <= next_req.off;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pool_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with no request pending: status %0d index %0d offset %h",
                   $realtime, status_o, block_index_o, block_offset_o);
        end
      end else begin
        want = pool_results_q.pop_front();
        if (status_o !== want.st || block_index_o !== want.idx ||
            block_offset_o !== want.boff) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch: status %0d/%0d index %0d/%0d offset %h/%h (exp/act)",
                     $realtime, want.st, status_o, want.idx, block_index_o,
                     want.boff, block_offset_o);
          end
        end
      end
    end
  end

  task automatic push_req(op_e op, logic [OFF_W-1:0] off);
    pool_req_t r;
    r.op = op;
    r.off = off;
    pend_q.push_back(r);
  endtask

  task automatic wait_idle();
    while (pend_q.size() != 0 || start || pool_results_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic cfg_write(logic idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BLK_BYTES) begin
      cfg_size = value;
    end else begin
      cfg_count = value[BC_W-1:0];
    end
  endtask

  task automatic set_phase(logic [CFG_W-1:0] size_v, logic [CFG_W-1:0] count_v,
                           int unsigned idle_v);
    wait_idle();
    repeat (SETTLE) @(negedge clk_i);
    cfg_write(CFG_BLK_BYTES, size_v);
    cfg_write(CFG_BLOCK_COUNT, count_v);
    idle_pct = idle_v;
  endtask

  // Mostly well-formed traffic: allocations and frees of blocks that are held,
  // with a lean toward one or the other per chunk so that the pool both drains
  // and refills. Frees of blocks that are not held only appear when dirty is set,
  // since a double free leaves a loop in the free stack for good.
  task automatic fill_chunk(bit dirty);
    int unsigned avail [$];
    int unsigned us;
    int unsigned cnt;
    int unsigned lim;
    int unsigned lean;
    int unsigned k;
    pool_req_t   r;
    avail = held_q;
    us = used_size();
    cnt = used_count();
    lim = us * cnt;
    lean = $urandom_range(85, 15);
    repeat (CHUNK) begin
      r.op = OP_ALLOC;
      r.off = OFF_W'($urandom);
      if ($urandom_range(99) < 12) begin
        r.op = OP_FREE;
        case ($urandom_range(dirty ? 3 : 2))
          1: if (cnt > 0) begin
            r.off = OFF_W'($urandom_range(cnt - 1) * us + $urandom_range(us - 1, 1));
          end
          2: r.off = (lim < (1 << OFF_W)) ? OFF_W'(lim) : OFF_W'(lim - 1);
          3: if (cnt > 0) begin
            r.off = OFF_W'($urandom_range(cnt - 1) * us);
          end
          default: ;
        endcase
        if (!dirty && 32'(r.off) < lim && 32'(r.off) % us == 0) begin
          r.off[0] = 1'b1;
        end
      end else if (avail.size() != 0 && $urandom_range(99) >= lean) begin
        k = $urandom_range(avail.size() - 1);
        r.op = OP_FREE;
        r.off = OFF_W'(avail[k] * us);
        avail.delete(k);
      end
      pend_q.push_back(r);
    end
  endtask

  task automatic random_chunks(int unsigned n, bit dirty);
    repeat (n) begin
      fill_chunk(dirty);
      wait_idle();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset configuration: 8-byte blocks, 256 of them.
    push_req(OP_ALLOC, 24'hFFFFFF);
    push_req(OP_ALLOC, 24'h000000);
    push_req(OP_ALLOC, 24'h000000);
    push_req(OP_FREE,  24'd8);
    push_req(OP_ALLOC, 24'd0);
    push_req(OP_FREE,  24'd0);
    push_req(OP_FREE,  24'd16);
    push_req(OP_ALLOC, 24'd0);
    push_req(OP_ALLOC, 24'd0);
    push_req(OP_FREE,  24'hFFFFFF);
    push_req(OP_FREE,  24'd2048);
    push_req(OP_FREE,  24'd2047);
    push_req(OP_FREE,  24'd4);
    push_req(OP_FREE,  24'd8);
    wait_idle();
    random_chunks(4, 1'b0);

    set_phase(16'd13, 16'd16, 73);
    random_chunks(5, 1'b0);
    set_phase(16'd65535, 16'd256, 33);
    random_chunks(4, 1'b0);
    // Count lowered to one block while earlier blocks are still out.
    set_phase(16'd0, 16'd1, 0);
    random_chunks(3, 1'b0);
    set_phase(16'd1000, 16'd511, 73);
    random_chunks(4, 1'b0);
    set_phase(16'($urandom_range(300, 8)), 16'($urandom_range(40, 2)), 33);
    random_chunks(5, 1'b0);
    set_phase(16'd24, 16'd0, 0);
    random_chunks(1, 1'b0);
    set_phase(16'd65528, 16'd3, 73);
    random_chunks(3, 1'b0);
    set_phase(16'($urandom_range(65535)), 16'($urandom_range(256, 1)), 0);
    random_chunks(5, 1'b0);

    // Last phase: frees of blocks never handed out and double frees.
    set_phase(16'd8, 16'd8, 33);
    push_req(OP_FREE,  24'd56);
    push_req(OP_FREE,  24'd0);
    push_req(OP_FREE,  24'd0);
    push_req(OP_ALLOC, 24'd0);
    push_req(OP_ALLOC, 24'd0);
    push_req(OP_ALLOC, 24'd0);
    wait_idle();
    random_chunks(4, 1'b1);

    repeat (SETTLE) @(negedge clk_i);
    if (mismatches == 0 && pool_results_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
